@@ hdl/bfiq_pkg.sv @@
// ----------------------------------------------------------------------------
// bfiq_pkg
// Shared types and constants of the Bloom filter insert/query core.
// ----------------------------------------------------------------------------
`default_nettype none

package bfiq_pkg;

   // digest layout
   localparam int NUM_WORDS = 8;
   localparam int WORD_W    = 32;
   localparam int STEP_W    = $clog2(WORD_W);

   // register widths
   localparam int FBITS_W    = 11;
   localparam int HCOUNT_W   = 4;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 11;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_FILTER_BITS = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HASH_COUNT  = 1'd1;

   // reset values
   localparam logic [FBITS_W-1:0]  FBITS_RESET  = 11'd1024;
   localparam logic [HCOUNT_W-1:0] HCOUNT_RESET = 4'd1;

   // request modes
   localparam logic MODE_ADD   = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef logic [WORD_W-1:0] word_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_step;  // write one zero of the post-reset clear
      logic load;        // capture request and config snapshot
      logic word_start;  // begin reducing the current digest word
      logic div_step;    // one restoring modulo step
      logic mem_access;  // read (query) or set (add) the indexed bit
      logic mem_check;   // fold read bit into membership, advance word
      logic rsp_load;    // move result into the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;  // clear pass is writing its last entry
      logic words_left;  // digest words still to process
      logic rsp_busy;    // output register holds an untaken result
   } status_type;

endpackage

`default_nettype wire

@@ hdl/bfiq_if.sv @@
// ----------------------------------------------------------------------------
// bfiq_req_if / bfiq_rsp_if
// Valid/ready channels carrying requests and responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfiq_req_if;
   logic                 valid;
   logic                 ready;
   logic                 mode;
   bfiq_pkg::word_type   hash_word_0;
   bfiq_pkg::word_type   hash_word_1;
   bfiq_pkg::word_type   hash_word_2;
   bfiq_pkg::word_type   hash_word_3;
   bfiq_pkg::word_type   hash_word_4;
   bfiq_pkg::word_type   hash_word_5;
   bfiq_pkg::word_type   hash_word_6;
   bfiq_pkg::word_type   hash_word_7;

   modport source (
      output valid, mode, hash_word_0, hash_word_1, hash_word_2, hash_word_3,
             hash_word_4, hash_word_5, hash_word_6, hash_word_7,
      input  ready
   );
   modport sink (
      input  valid, mode, hash_word_0, hash_word_1, hash_word_2, hash_word_3,
             hash_word_4, hash_word_5, hash_word_6, hash_word_7,
      output ready
   );
endinterface

interface bfiq_rsp_if;
   logic valid;
   logic ready;
   logic is_member;
   logic was_query;

   modport source (output valid, is_member, was_query, input ready);
   modport sink   (input valid, is_member, was_query, output ready);
endinterface

`default_nettype wire

@@ hdl/bfiq_ram.sv @@
// ----------------------------------------------------------------------------
// bfiq_ram
// Single-port RAM, one write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfiq_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ hdl/bfiq_ctrl.sv @@
// ----------------------------------------------------------------------------
// bfiq_ctrl
// Sequencer: clear pass, then per request one modulo/access pass per used word.
// ----------------------------------------------------------------------------
`default_nettype none

module bfiq_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire bfiq_pkg::status_type status,
   output bfiq_pkg::cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WORD,
      ST_DIV,
      ST_ACCESS,
      ST_CHECK,
      ST_FINISH
   } state_type;

   localparam logic [bfiq_pkg::STEP_W-1:0] STEP_LAST =
      bfiq_pkg::STEP_W'(bfiq_pkg::WORD_W - 1);

   state_type                     state_ff;
   logic [bfiq_pkg::STEP_W-1:0]   step_ff;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR:  cmd.clear_step = 1'b1;
         ST_IDLE:   cmd.load       = req_valid;
         ST_WORD:   cmd.word_start = status.words_left;
         ST_DIV:    cmd.div_step   = 1'b1;
         ST_ACCESS: cmd.mem_access = 1'b1;
         ST_CHECK:  cmd.mem_check  = 1'b1;
         ST_FINISH: cmd.rsp_load   = !status.rsp_busy;
         default:   cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         step_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               if (status.clear_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_WORD;
               end
            end
            ST_WORD: begin
               step_ff <= '0;
               if (status.words_left) begin
                  state_ff <= ST_DIV;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_DIV: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_LAST) begin
                  state_ff <= ST_ACCESS;
               end
            end
            ST_ACCESS: state_ff <= ST_CHECK;
            ST_CHECK:  state_ff <= ST_WORD;
            ST_FINISH: begin
               if (!status.rsp_busy) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_CLEAR;
         endcase
      end
   end

endmodule

`default_nettype wire

@@ hdl/bfiq_dp.sv @@
// ----------------------------------------------------------------------------
// bfiq_dp
// Datapath: registers, digest word shift line, bit-serial modulo, bit store,
// membership flag and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfiq_dp #(
   parameter int MAX_BITS   = 1024,
   parameter int MAX_HASHES = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [bfiq_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire logic [bfiq_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                                req_mode,
   input  wire bfiq_pkg::word_type                  req_words [bfiq_pkg::NUM_WORDS],
   input  wire logic                                rsp_ready,
   output logic                                     rsp_valid,
   output logic                                     rsp_is_member,
   output logic                                     rsp_was_query,
   input  wire bfiq_pkg::cmd_type                   cmd,
   output bfiq_pkg::status_type                     status
);

   localparam int IDX_W = $clog2(MAX_BITS);
   // remainder must hold 2*m-1 for m up to the 11-bit register or MAX_BITS
   localparam int REM_W = (IDX_W + 1 > 12) ? IDX_W + 1 : 12;
   localparam logic [IDX_W-1:0] CLEAR_LAST = IDX_W'(MAX_BITS - 1);

   logic [bfiq_pkg::FBITS_W-1:0]  filter_bits_ff;
   logic [bfiq_pkg::HCOUNT_W-1:0] hash_count_ff;

   logic                          mode_ff;
   bfiq_pkg::word_type            words_ff [bfiq_pkg::NUM_WORDS];
   logic [REM_W-1:0]              modulus_ff;
   logic [bfiq_pkg::HCOUNT_W-1:0] hashes_left_ff;
   logic                          member_ff;
   bfiq_pkg::word_type            shift_ff;
   logic [REM_W-1:0]              rem_ff;
   logic [REM_W-1:0]              rem_in;
   logic [REM_W-1:0]              modulus_in;
   logic [bfiq_pkg::HCOUNT_W-1:0] hashes_in;

   logic [IDX_W-1:0]              clear_addr_ff;
   logic                          rsp_valid_ff;
   logic                          is_member_ff;
   logic                          was_query_ff;

   logic                          ram_we;
   logic [IDX_W-1:0]              ram_addr;
   logic                          ram_wdata;
   logic                          ram_rdata;

   // ---- configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_bits_ff <= bfiq_pkg::FBITS_RESET;
         hash_count_ff  <= bfiq_pkg::HCOUNT_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            bfiq_pkg::CSR_FILTER_BITS: filter_bits_ff <= csr_wdata;
            bfiq_pkg::CSR_HASH_COUNT:
               hash_count_ff <= csr_wdata[bfiq_pkg::HCOUNT_W-1:0];
         endcase
      end
   end

   // ---- effective modulus and hash count, snapped at load
   always_comb begin
      if (filter_bits_ff == '0) begin
         modulus_in = REM_W'(1);
      end else if (32'(filter_bits_ff) > 32'(MAX_BITS)) begin
         modulus_in = REM_W'(MAX_BITS);
      end else begin
         modulus_in = REM_W'(filter_bits_ff);
      end
      if (32'(hash_count_ff) > 32'(MAX_HASHES)) begin
         hashes_in = bfiq_pkg::HCOUNT_W'(MAX_HASHES);
      end else begin
         hashes_in = hash_count_ff;
      end
   end

   // restoring step: rem < m on entry, so 2*rem+1 < 2*m fits REM_W
   always_comb begin
      rem_in = {rem_ff[REM_W-2:0], shift_ff[bfiq_pkg::WORD_W-1]};
      if (rem_in >= modulus_ff) begin
         rem_in = rem_in - modulus_ff;
      end
   end

   // ---- item registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff    <= req_mode;
         words_ff   <= req_words;
         modulus_ff <= modulus_in;
         member_ff  <= 1'b1;
      end
      if (cmd.word_start) begin
         shift_ff <= words_ff[0];
         rem_ff   <= '0;
      end else if (cmd.div_step) begin
         shift_ff <= {shift_ff[bfiq_pkg::WORD_W-2:0], 1'b0};
         rem_ff   <= rem_in;
      end
      if (cmd.mem_check) begin
         if (!ram_rdata) begin
            member_ff <= 1'b0;
         end
         for (int i = 0; i < bfiq_pkg::NUM_WORDS - 1; i++) begin
            words_ff[i] <= words_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hashes_left_ff <= '0;
      end else if (cmd.load) begin
         hashes_left_ff <= hashes_in;
      end else if (cmd.mem_check) begin
         hashes_left_ff <= hashes_left_ff - 1'b1;
      end
   end

   // ---- clear pass address
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
      end else if (cmd.clear_step) begin
         clear_addr_ff <= clear_addr_ff + 1'b1;
      end
   end

   // ---- bit store
   always_comb begin
      if (cmd.clear_step) begin
         ram_we    = 1'b1;
         ram_addr  = clear_addr_ff;
         ram_wdata = 1'b0;
      end else begin
         ram_we    = cmd.mem_access && (mode_ff == bfiq_pkg::MODE_ADD);
         ram_addr  = rem_ff[IDX_W-1:0];
         ram_wdata = 1'b1;
      end
   end

   bfiq_ram #(
      .WIDTH (1),
      .DEPTH (MAX_BITS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // ---- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         is_member_ff <= (mode_ff == bfiq_pkg::MODE_QUERY) && member_ff;
         was_query_ff <= mode_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_is_member = is_member_ff;
   assign rsp_was_query = was_query_ff;

   assign status.clear_last = (clear_addr_ff == CLEAR_LAST);
   assign status.words_left = (hashes_left_ff != '0);
   assign status.rsp_busy   = rsp_valid_ff && !rsp_ready;

endmodule

`default_nettype wire

@@ hdl/bloom_filter_insert_query_core.sv @@
// ----------------------------------------------------------------------------
// bloom_filter_insert_query_core
// Bloom filter add/query over a bit store indexed by precomputed digest words.
// ----------------------------------------------------------------------------
// Each request carries eight 32-bit digest words and a mode (add or query).
// For each of the first K words (K = hash_count, capped at MAX_HASHES) the
// word is reduced modulo filter_bits (0 taken as 1, capped at MAX_BITS) to a
// bit index; an add sets those bits, a query answers is_member = 1 only if
// all are set (K = 0 always hits). Every request yields exactly one response;
// is_member is 0 for adds. After reset the store is cleared one bit per
// cycle, during which req_bus.ready stays low (register writes are still
// taken). A request then passes, for each used word, through the word
// setup, the bit-serial restoring modulo, the store access and the
// registered read-back, all through the single store port, and is done
// before the next is taken. The response sits in an output register, so a
// new request is taken while the previous response still waits for
// rsp_bus.ready. Registers must only be written while no request is in
// flight.
// ----------------------------------------------------------------------------
`default_nettype none

module bloom_filter_insert_query_core #(
   parameter int MAX_BITS   = 1024,
   parameter int MAX_HASHES = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // configuration write port
   input  wire logic                            csr_we,
   input  wire logic [bfiq_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [bfiq_pkg::CSR_DATA_W-1:0] csr_wdata,
   // request and response channels
   bfiq_req_if.sink                             req_bus,
   bfiq_rsp_if.source                           rsp_bus
);

   bfiq_pkg::cmd_type    cmd;
   bfiq_pkg::status_type status;
   bfiq_pkg::word_type   req_words [bfiq_pkg::NUM_WORDS];

   // digest words in order, word 0 used first
   assign req_words[0] = req_bus.hash_word_0;
   assign req_words[1] = req_bus.hash_word_1;
   assign req_words[2] = req_bus.hash_word_2;
   assign req_words[3] = req_bus.hash_word_3;
   assign req_words[4] = req_bus.hash_word_4;
   assign req_words[5] = req_bus.hash_word_5;
   assign req_words[6] = req_bus.hash_word_6;
   assign req_words[7] = req_bus.hash_word_7;

   // sequencer: owns the handshake on the request side
   bfiq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: registers, modulo unit, store, output register
   bfiq_dp #(
      .MAX_BITS   (MAX_BITS),
      .MAX_HASHES (MAX_HASHES)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .req_mode      (req_bus.mode),
      .req_words     (req_words),
      .rsp_ready     (rsp_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .rsp_is_member (rsp_bus.is_member),
      .rsp_was_query (rsp_bus.was_query),
      .cmd           (cmd),
      .status        (status)
   );

endmodule

`default_nettype wire

@@ hdl/bfiq_checker.sv @@
// ----------------------------------------------------------------------------
// bfiq_checker
// Port-level checks of the Bloom filter core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bfiq_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_is_member,
   input wire logic rsp_was_query
);

   // response held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_is_member) && $stable(rsp_was_query))
      else $error("stalled response changed");

   // one request in work at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

   // store clear runs after reset, nothing pending
   a_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("not quiet after reset");

   // adds never report membership
   a_add_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_was_query |-> !rsp_is_member)
      else $error("add response reports a hit");

endmodule

bind bloom_filter_insert_query_core bfiq_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_is_member (rsp_bus.is_member),
   .rsp_was_query (rsp_bus.was_query)
);

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Bloom filter insert/query core: requests go in
// over valid/ready with random gaps and back-pressure, each accepted request
// is applied to a local bit-store image (adds set its bits), and every response is compared with the prediction.
// ----------------------------------------------------------------------------

module tb;

   localparam int CLK_PERIOD     = 12;
   localparam int STORE_DEPTH    = 1024;
   localparam int HASH_LIMIT     = 8;
   localparam int RESET_CYCLES   = 8;
   // long enough for a request at K = 8, plus margin
   localparam int SETTLE_CYCLES  = 320;
   localparam int TIMEOUT_CYCLES = 4_000_000;
   localparam int SEGMENTS       = 11;
   localparam int SEG_ITEMS      = 100;
   localparam int HISTORY_DEPTH  = 64;
   // marks a segment setting that is drawn at random
   localparam int PICK_RANDOM    = 'hFFFF;

   typedef logic [bfiq_pkg::NUM_WORDS-1:0][bfiq_pkg::WORD_W-1:0] digest_type;

   typedef struct packed {
      logic       mode;
      digest_type word;
   } digest_req_type;

   typedef struct packed {
      logic is_member;
      logic was_query;
   } member_rsp_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [bfiq_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [bfiq_pkg::CSR_DATA_W-1:0] csr_wdata;

   bfiq_req_if req_bus ();
   bfiq_rsp_if rsp_bus ();

   bloom_filter_insert_query_core #(
      .MAX_BITS   (STORE_DEPTH),
      .MAX_HASHES (HASH_LIMIT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   // local image of the filter: bit store plus register copies
   logic                           store_image [STORE_DEPTH];
   logic [bfiq_pkg::FBITS_W-1:0]   cfg_filter_bits;
   logic [bfiq_pkg::HCOUNT_W-1:0]  cfg_hash_count;

   member_rsp_type expected_rsp [$];
   digest_type     added_digests [$];   // recent adds, replayed as queries to get hits

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned mismatch_count;
   int unsigned rsp_count;

   // ------------------------------------------------------------------------
   // clock, reset, watchdog
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      repeat (TIMEOUT_CYCLES) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   // ------------------------------------------------------------------------
   // response side: random back-pressure, driven on the falling edge
   // ------------------------------------------------------------------------
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic void note_mismatch(string field, logic want, logic got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("response %0d: %s expected %b, got %b", rsp_count, field, want, got);
   endfunction

   // every accepted response is checked against the oldest expectation
   always @(posedge clock) begin : rsp_check
      member_rsp_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("response %0d: no request outstanding (is_member %b, was_query %b)",
                        rsp_count, rsp_bus.is_member, rsp_bus.was_query);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_bus.is_member !== want.is_member)
               note_mismatch("is_member", want.is_member, rsp_bus.is_member);
            if (rsp_bus.was_query !== want.was_query)
               note_mismatch("was_query", want.was_query, rsp_bus.was_query);
         end
         rsp_count++;
      end
   end

   // ------------------------------------------------------------------------
   // filter prediction
   // ------------------------------------------------------------------------
   // Reduce each used word to an index: a bit count of zero acts as one, and
   // counts past the store size or hash counts past the word count saturate.
   // Adds set the bits and answer 0; queries hit only if every bit is set.
   function automatic member_rsp_type apply_to_filter(digest_req_type r);
      member_rsp_type res;
      int unsigned modulus, hashes, idx;
      modulus = cfg_filter_bits;
      if (modulus == 0) modulus = 1;
      if (modulus > STORE_DEPTH) modulus = STORE_DEPTH;
      hashes = cfg_hash_count;
      if (hashes > HASH_LIMIT) hashes = HASH_LIMIT;
      res.is_member = 1'b1;
      res.was_query = r.mode;
      for (int i = 0; i < hashes; i++) begin
         idx = r.word[i] % modulus;
         if (r.mode == bfiq_pkg::MODE_QUERY) begin
            if (!store_image[idx]) res.is_member = 1'b0;
         end else begin
            store_image[idx] = 1'b1;
         end
      end
      if (r.mode == bfiq_pkg::MODE_ADD) res.is_member = 1'b0;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   // All driver tasks start and end on a falling edge at which nothing has
   // been assigned yet, so valid is never lowered and raised in one step.
   task automatic send_request(input digest_req_type r);
      // stay idle, with valid low, while the random draw falls under send_idle_pct
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.mode        <= r.mode;
      req_bus.hash_word_0 <= r.word[0];
      req_bus.hash_word_1 <= r.word[1];
      req_bus.hash_word_2 <= r.word[2];
      req_bus.hash_word_3 <= r.word[3];
      req_bus.hash_word_4 <= r.word[4];
      req_bus.hash_word_5 <= r.word[5];
      req_bus.hash_word_6 <= r.word[6];
      req_bus.hash_word_7 <= r.word[7];
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      expected_rsp.push_back(apply_to_filter(r));
      if (r.mode == bfiq_pkg::MODE_ADD) begin
         added_digests.push_back(r.word);
         if (added_digests.size() > HISTORY_DEPTH) void'(added_digests.pop_front());
      end
      @(negedge clock);
   endtask

   // drop valid and hold off until every outstanding response has come back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (expected_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [bfiq_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [bfiq_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      // filter bits keeps the whole data word; hash count keeps only its low bits
      if (addr == bfiq_pkg::CSR_FILTER_BITS) cfg_filter_bits = data[bfiq_pkg::FBITS_W-1:0];
      else                                   cfg_hash_count  = data[bfiq_pkg::HCOUNT_W-1:0];
      @(negedge clock);
   endtask

   task automatic configure(input int unsigned bits, input int unsigned hashes);
      wait_drained();
      write_csr(bfiq_pkg::CSR_FILTER_BITS, bits[bfiq_pkg::CSR_DATA_W-1:0]);
      write_csr(bfiq_pkg::CSR_HASH_COUNT, hashes[bfiq_pkg::CSR_DATA_W-1:0]);
   endtask

   function automatic digest_req_type uniform_request(logic mode, bfiq_pkg::word_type w);
      digest_req_type r;
      r.mode = mode;
      for (int i = 0; i < bfiq_pkg::NUM_WORDS; i++) r.word[i] = w;
      return r;
   endfunction

   // Queries mostly replay a recent add (hit) or a replay with one word
   // changed (near miss); the rest, and all adds, carry fresh digests.
   function automatic digest_req_type random_request();
      digest_req_type r;
      int unsigned pick;
      r.mode = ($urandom_range(1) == 1) ? bfiq_pkg::MODE_QUERY : bfiq_pkg::MODE_ADD;
      pick = $urandom_range(99);
      for (int i = 0; i < bfiq_pkg::NUM_WORDS; i++)
         r.word[i] = (pick >= 90) ? bfiq_pkg::word_type'($urandom_range(2047))
                                  : bfiq_pkg::word_type'($urandom);
      if (r.mode == bfiq_pkg::MODE_QUERY && added_digests.size() != 0 && pick < 60) begin
         r.word = added_digests[$urandom_range(added_digests.size() - 1)];
         if (pick >= 40) r.word[$urandom_range(bfiq_pkg::NUM_WORDS - 1)] = $urandom;
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   // Reset values (1024 bits, one hash): only word 0 counts, wrapping at 1024.
   task automatic test_reset_defaults();
      digest_req_type r;
      r = uniform_request(bfiq_pkg::MODE_ADD, 32'd5);
      for (int i = 1; i < bfiq_pkg::NUM_WORDS; i++) r.word[i] = $urandom;
      send_request(r);
      r = uniform_request(bfiq_pkg::MODE_QUERY, 32'd1029);
      for (int i = 1; i < bfiq_pkg::NUM_WORDS; i++) r.word[i] = $urandom;
      send_request(r);
      send_request(uniform_request(bfiq_pkg::MODE_QUERY, 32'd6));
   endtask

   // Word extremes with all eight hashes: top index, zero, toggling patterns.
   task automatic test_word_extremes();
      digest_req_type r;
      configure(STORE_DEPTH, HASH_LIMIT);
      send_request(uniform_request(bfiq_pkg::MODE_ADD, 32'hFFFF_FFFF));
      send_request(uniform_request(bfiq_pkg::MODE_QUERY, 32'hFFFF_FFFF));
      send_request(uniform_request(bfiq_pkg::MODE_QUERY, 32'h0000_0000));
      for (int i = 0; i < bfiq_pkg::NUM_WORDS; i++)
         r.word[i] = i[0] ? 32'hAAAA_AAAA : 32'h5555_5555;
      r.mode = bfiq_pkg::MODE_ADD;
      send_request(r);
      r.mode = bfiq_pkg::MODE_QUERY;
      send_request(r);
      send_request(uniform_request(bfiq_pkg::MODE_ADD, 32'h8000_0000));
   endtask

   // Bit count of zero folds every index to 0; counts past 1024 saturate.
   task automatic test_bit_count_edges();
      configure(0, 3);
      send_request(random_request());
      send_request(uniform_request(bfiq_pkg::MODE_ADD, $urandom));
      send_request(uniform_request(bfiq_pkg::MODE_QUERY, $urandom));
      configure(2047, 1);
      send_request(uniform_request(bfiq_pkg::MODE_QUERY, 32'd2047));
      send_request(uniform_request(bfiq_pkg::MODE_QUERY, 32'd2000));
      configure(1, 2);
      send_request(uniform_request(bfiq_pkg::MODE_QUERY, $urandom));
   endtask

   // Zero hashes always hit; oversized counts saturate, wide data is cut.
   task automatic test_hash_count_edges();
      configure(STORE_DEPTH, 0);
      send_request(uniform_request(bfiq_pkg::MODE_QUERY, $urandom));
      send_request(uniform_request(bfiq_pkg::MODE_ADD, $urandom));
      configure(STORE_DEPTH, 'h7F9);
      send_request(uniform_request(bfiq_pkg::MODE_QUERY, 32'h8000_0000));
      configure(STORE_DEPTH, 15);
      send_request(uniform_request(bfiq_pkg::MODE_QUERY, 32'hFFFF_FC00));
   endtask

   // Random traffic in segments, each with its own register setting and
   // handshake pressure; each change waits for the pipe to drain first.
   task automatic test_random_traffic();
      int unsigned seg_bits   [SEGMENTS] = '{1024, 1, 8, 2047, PICK_RANDOM, 0, 37,
                                              PICK_RANDOM, 1024, 16, PICK_RANDOM};
      int unsigned seg_hashes [SEGMENTS] = '{8, 3, 15, 5, PICK_RANDOM, 2, 9,
                                              PICK_RANDOM, 1, 4, PICK_RANDOM};
      int unsigned bits, hashes;
      for (int s = 0; s < SEGMENTS; s++) begin
         bits   = (seg_bits[s] == PICK_RANDOM) ? $urandom_range(1, STORE_DEPTH) : seg_bits[s];
         hashes = (seg_hashes[s] == PICK_RANDOM) ? $urandom_range(15) : seg_hashes[s];
         configure(bits, hashes);
         if (s < 4) begin
            send_idle_pct = 16;
            recv_idle_pct = 57;
         end else if (s < 8) begin
            send_idle_pct = 57;
            recv_idle_pct = 16;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int n = 0; n < SEG_ITEMS; n++) send_request(random_request());
      end
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_addr            = '0;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.mode        = bfiq_pkg::MODE_ADD;
      req_bus.hash_word_0 = '0;
      req_bus.hash_word_1 = '0;
      req_bus.hash_word_2 = '0;
      req_bus.hash_word_3 = '0;
      req_bus.hash_word_4 = '0;
      req_bus.hash_word_5 = '0;
      req_bus.hash_word_6 = '0;
      req_bus.hash_word_7 = '0;
      send_idle_pct       = 16;
      recv_idle_pct       = 57;
      mismatch_count      = 0;
      rsp_count           = 0;
      cfg_filter_bits     = bfiq_pkg::FBITS_RESET;
      cfg_hash_count      = bfiq_pkg::HCOUNT_RESET;
      foreach (store_image[i]) store_image[i] = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // the post-reset clear pass holds ready low; send_request just waits
      test_reset_defaults();
      test_word_extremes();
      test_bit_count_edges();
      test_hash_count_edges();
      test_random_traffic();

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
